@@ hw/rtl/i2cmw_pkg.sv @@
`default_nettype none

package i2cmw_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TICK_W = 8;
	localparam int unsigned BIT_CNT_W = 4;
	localparam int unsigned CFG_ADDR_W = 2;

	localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = BIT_CNT_W'(8);

	localparam logic [TICK_W-1:0] SETUP_TICKS_RST = TICK_W'(2);
	localparam logic [TICK_W-1:0] HIGH_TICKS_RST = TICK_W'(3);
	localparam logic [TICK_W-1:0] HOLD_TICKS_RST = TICK_W'(5);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SETUP_TICKS = 2'd0,
		CFG_HIGH_TICKS  = 2'd1,
		CFG_HOLD_TICKS  = 2'd2
	} cfg_addr_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_A    = 4'd1,
		PH_START_B    = 4'd2,
		PH_BIT_SETUP  = 4'd3,
		PH_BIT_HIGH   = 4'd4,
		PH_ACK_SETUP  = 4'd5,
		PH_ACK_HIGH   = 4'd6,
		PH_WAIT       = 4'd7,
		PH_STOP_SETUP = 4'd8,
		PH_STOP_A     = 4'd9,
		PH_STOP_B     = 4'd10
	} phase_t;

	typedef struct packed {
		logic              cmd_valid;
		logic [BYTE_W-1:0] cmd_byte;
		logic              cmd_stop;
		logic              sda_in;
	} cmd_t;

	typedef struct packed {
		logic scl_out;
		logic sda_out;
		logic ready_res;
		logic byte_done;
		logic byte_acked;
		logic trans_done;
		logic trans_ok;
	} res_t;

	typedef struct packed {
		logic [TICK_W-1:0] setup_ticks;
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] hold_ticks;
	} timing_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2cmw_ifs.sv @@
`default_nettype none

interface i2cmw_cmd_if;
	logic            valid;
	logic            ready;
	i2cmw_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cmw_res_if;
	logic            valid;
	logic            ready;
	i2cmw_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cmw_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [i2cmw_pkg::CFG_ADDR_W-1:0]     addr;
	logic [i2cmw_pkg::TICK_W-1:0]         wdata;

	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2c_master_write_sequencer_unit.sv @@
`default_nettype none

// Write-only I2C master stepped by one bus tick per cmd item: each accepted item is one
// timebase tick carrying the offered byte, its last-byte flag and the sampled SDA level, and
// it yields exactly one res item with the SCL/SDA drive levels and status pulses for that
// tick. One item is taken per clock while res is not stalled: it is registered in cmd_s1,
// then its result is loaded into the output register res_q, where it can be accepted. A
// stalled res channel holds results and back-pressures cmd. The user must write the timing
// registers (setup, high, hold tick counts, index 0 to 2) on cfg only while no items are in
// flight; the block itself does not enforce it.
module i2c_master_write_sequencer_unit (
	input  wire         clk,
	input  wire         arst_n,
	i2cmw_cmd_if.sink   cmd,
	i2cmw_res_if.source res,
	i2cmw_cfg_if.sink   cfg
);
	import i2cmw_pkg::*;

	cmd_t    cmd_s1;
	logic    vld_s1;
	res_t    res_q;
	logic    vld_q;
	res_t    step_res;
	timing_t timing;
	logic    adv;

	assign adv       = vld_s1 && (!vld_q || res.ready);
	assign cmd.ready = !vld_s1 || adv;
	assign res.valid = vld_q;
	assign res.data  = res_q;

	i2cmw_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.timing (timing)
	);

	i2cmw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (cmd_s1),
		.timing (timing),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (cmd.ready) begin
				vld_s1 <= cmd.valid;
			end
			if (adv) begin
				vld_q <= 1'b1;
			end else if (res.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (adv) begin
			res_q <= step_res;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/i2cmw_cfg_regs.sv @@
`default_nettype none

module i2cmw_cfg_regs (
	input  wire                 clk,
	input  wire                 arst_n,
	i2cmw_cfg_if.sink           cfg,
	output i2cmw_pkg::timing_t  timing
);
	import i2cmw_pkg::*;

	timing_t timing_q;

	assign cfg.ready = 1'b1;
	assign timing = timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.setup_ticks <= SETUP_TICKS_RST;
			timing_q.high_ticks  <= HIGH_TICKS_RST;
			timing_q.hold_ticks  <= HOLD_TICKS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_addr_t'(cfg.addr))
				CFG_SETUP_TICKS: timing_q.setup_ticks <= cfg.wdata;
				CFG_HIGH_TICKS:  timing_q.high_ticks  <= cfg.wdata;
				CFG_HOLD_TICKS:  timing_q.hold_ticks  <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/i2cmw_core.sv @@
`default_nettype none

module i2cmw_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  wire i2cmw_pkg::cmd_t    item,
	input  wire i2cmw_pkg::timing_t timing,
	output i2cmw_pkg::res_t     res
);
	import i2cmw_pkg::*;

	phase_t                phase_q, phase_d;
	logic [TICK_W-1:0]     tick_q, tick_d, tick_inc;
	logic [BIT_CNT_W-1:0]  bit_q, bit_d, bit_inc;
	logic [BYTE_W-1:0]     sr_q, sr_d, sr_ack;
	logic                  stop_q, stop_d;
	logic                  fail_q, fail_d;
	logic                  disc_q, disc_d;
	logic                  hit_setup, hit_high, hit_hold;

	function automatic logic lim_hit(logic [TICK_W-1:0] cnt, logic [TICK_W-1:0] lim);
		return ({1'b0, cnt} + (TICK_W+1)'(1)) >= {1'b0, lim};
	endfunction

	assign tick_inc  = tick_q + TICK_W'(1);
	assign bit_inc   = bit_q + BIT_CNT_W'(1);
	assign hit_setup = lim_hit(tick_q, timing.setup_ticks);
	assign hit_high  = lim_hit(tick_q, timing.high_ticks);
	assign hit_hold  = lim_hit(tick_q, timing.hold_ticks);
	assign sr_ack    = (tick_q == '0) ? {sr_q[BYTE_W-1:1], item.sda_in} : sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			sr_q    <= '0;
			stop_q  <= 1'b0;
			fail_q  <= 1'b0;
			disc_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			sr_q    <= sr_d;
			stop_q  <= stop_d;
			fail_q  <= fail_d;
			disc_q  <= disc_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		sr_d    = sr_q;
		stop_d  = stop_q;
		fail_d  = fail_q;
		disc_d  = disc_q;
		res         = '0;
		res.scl_out = 1'b1;
		res.sda_out = 1'b1;
		unique case (phase_q)
			PH_IDLE: begin
				res.ready_res = 1'b1;
				if (item.cmd_valid) begin
					if (disc_q) begin
						if (item.cmd_stop) begin
							disc_d = 1'b0;
						end
					end else begin
						sr_d    = item.cmd_byte;
						stop_d  = item.cmd_stop;
						fail_d  = 1'b0;
						tick_d  = '0;
						phase_d = PH_START_A;
					end
				end
			end
			PH_START_A: begin
				tick_d = hit_hold ? '0 : tick_inc;
				if (hit_hold) begin
					phase_d = PH_START_B;
				end
			end
			PH_START_B: begin
				res.sda_out = 1'b0;
				tick_d = hit_hold ? '0 : tick_inc;
				if (hit_hold) begin
					bit_d   = '0;
					phase_d = PH_BIT_SETUP;
				end
			end
			PH_BIT_SETUP: begin
				res.scl_out = 1'b0;
				res.sda_out = sr_q[BYTE_W-1];
				tick_d = hit_setup ? '0 : tick_inc;
				if (hit_setup) begin
					phase_d = PH_BIT_HIGH;
				end
			end
			PH_BIT_HIGH: begin
				res.sda_out = sr_q[BYTE_W-1];
				tick_d = hit_high ? '0 : tick_inc;
				if (hit_high) begin
					sr_d    = {sr_q[BYTE_W-2:0], 1'b0};
					bit_d   = bit_inc;
					phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_SETUP : PH_BIT_SETUP;
				end
			end
			PH_ACK_SETUP: begin
				res.scl_out = 1'b0;
				tick_d = hit_setup ? '0 : tick_inc;
				if (hit_setup) begin
					phase_d = PH_ACK_HIGH;
				end
			end
			PH_ACK_HIGH: begin
				sr_d   = sr_ack;
				tick_d = hit_high ? '0 : tick_inc;
				if (hit_high) begin
					res.byte_done  = 1'b1;
					res.byte_acked = !sr_ack[0];
					sr_d = '0;
					if (sr_ack[0]) begin
						fail_d  = 1'b1;
						disc_d  = !stop_q;
						phase_d = PH_STOP_SETUP;
					end else begin
						phase_d = stop_q ? PH_STOP_SETUP : PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				res.scl_out   = 1'b0;
				res.ready_res = 1'b1;
				if (item.cmd_valid) begin
					sr_d    = item.cmd_byte;
					stop_d  = item.cmd_stop;
					bit_d   = '0;
					tick_d  = '0;
					phase_d = PH_BIT_SETUP;
				end
			end
			PH_STOP_SETUP: begin
				res.scl_out = 1'b0;
				res.sda_out = 1'b0;
				tick_d = hit_setup ? '0 : tick_inc;
				if (hit_setup) begin
					phase_d = PH_STOP_A;
				end
			end
			PH_STOP_A: begin
				res.sda_out = 1'b0;
				tick_d = hit_hold ? '0 : tick_inc;
				if (hit_hold) begin
					phase_d = PH_STOP_B;
				end
			end
			PH_STOP_B: begin
				tick_d = hit_hold ? '0 : tick_inc;
				if (hit_hold) begin
					res.trans_done = 1'b1;
					res.trans_ok   = !fail_q;
					phase_d        = PH_IDLE;
				end
			end
			default: begin
				tick_d  = '0;
				phase_d = PH_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ tb/i2c_master_write_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps

module i2c_master_write_sequencer_unit_tb;
	import i2cmw_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP = 50;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	i2cmw_cmd_if cmd_ch ();
	i2cmw_res_if res_ch ();
	i2cmw_cfg_if cfg_ch ();

	i2c_master_write_sequencer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// predicted bus state
	timing_t     tmg;
	phase_t      ph;
	logic [7:0]  tcnt;
	logic [7:0]  sreg;
	logic [3:0]  bcnt;
	logic        trans_failed;
	logic        stop_after;
	logic        discarding;

	res_t        bus_levels_q[$];
	int          errors;
	int          cycles;
	bit          gaps_on;
	int          hold_req;

	task automatic report(string msg);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("[cycle %0d] %s", cycles, msg);
		end
	endtask

	function automatic bit tick_done(logic [7:0] lim);
		if (int'(tcnt) + 1 >= int'(lim)) begin
			tcnt = '0;
			return 1'b1;
		end
		tcnt = tcnt + 8'd1;
		return 1'b0;
	endfunction

	function automatic res_t step_bus(cmd_t c);
		res_t r;
		logic msb;
		logic acked;
		r = '{scl_out: 1'b1, sda_out: 1'b1, default: 1'b0};
		msb = sreg[7];
		case (ph)
			PH_IDLE: begin
				r.ready_res = 1'b1;
				if (c.cmd_valid) begin
					if (discarding) begin
						if (c.cmd_stop) discarding = 1'b0;
					end else begin
						sreg = c.cmd_byte;
						stop_after = c.cmd_stop;
						trans_failed = 1'b0;
						tcnt = '0;
						ph = PH_START_A;
					end
				end
			end
			PH_START_A: begin
				if (tick_done(tmg.hold_ticks)) ph = PH_START_B;
			end
			PH_START_B: begin
				r.sda_out = 1'b0;
				if (tick_done(tmg.hold_ticks)) begin
					bcnt = '0;
					ph = PH_BIT_SETUP;
				end
			end
			PH_BIT_SETUP: begin
				r.scl_out = 1'b0;
				r.sda_out = msb;
				if (tick_done(tmg.setup_ticks)) ph = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				r.sda_out = msb;
				if (tick_done(tmg.high_ticks)) begin
					sreg = sreg << 1;
					bcnt = bcnt + 4'd1;
					ph = (bcnt >= BITS_PER_BYTE) ? PH_ACK_SETUP : PH_BIT_SETUP;
				end
			end
			PH_ACK_SETUP: begin
				r.scl_out = 1'b0;
				if (tick_done(tmg.setup_ticks)) ph = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				if (tcnt == 8'd0) sreg[0] = c.sda_in;
				if (tick_done(tmg.high_ticks)) begin
					acked = !sreg[0];
					r.byte_done = 1'b1;
					r.byte_acked = acked;
					sreg = '0;
					if (!acked) begin
						trans_failed = 1'b1;
						discarding = !stop_after;
						ph = PH_STOP_SETUP;
					end else begin
						ph = stop_after ? PH_STOP_SETUP : PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				r.scl_out = 1'b0;
				r.ready_res = 1'b1;
				if (c.cmd_valid) begin
					sreg = c.cmd_byte;
					stop_after = c.cmd_stop;
					bcnt = '0;
					tcnt = '0;
					ph = PH_BIT_SETUP;
				end
			end
			PH_STOP_SETUP: begin
				r.scl_out = 1'b0;
				r.sda_out = 1'b0;
				if (tick_done(tmg.setup_ticks)) ph = PH_STOP_A;
			end
			PH_STOP_A: begin
				r.sda_out = 1'b0;
				if (tick_done(tmg.hold_ticks)) ph = PH_STOP_B;
			end
			PH_STOP_B: begin
				if (tick_done(tmg.hold_ticks)) begin
					r.trans_done = 1'b1;
					r.trans_ok = !trans_failed;
					ph = PH_IDLE;
				end
			end
			default: begin
				tcnt = '0;
				ph = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	task automatic send_tick(cmd_t c);
		int gap;
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		bus_levels_q.push_back(step_bus(c));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (bus_levels_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_SETUP_TICKS: tmg.setup_ticks = val;
			CFG_HIGH_TICKS:  tmg.high_ticks = val;
			CFG_HOLD_TICKS:  tmg.hold_ticks = val;
			default: ;
		endcase
	endtask

	// bring the bus back to idle, let results drain, then rewrite the timing
	task automatic set_timing(logic [7:0] s, logic [7:0] h, logic [7:0] d);
		cmd_t c;
		while (ph != PH_IDLE) begin
			c.cmd_valid = (ph == PH_WAIT);
			c.cmd_byte = 8'($urandom);
			c.cmd_stop = 1'b1;
			c.sda_in = 1'b0;
			send_tick(c);
		end
		drain();
		repeat (4) @(posedge clk);
		write_reg(CFG_SETUP_TICKS, s);
		write_reg(CFG_HIGH_TICKS, h);
		write_reg(CFG_HOLD_TICKS, d);
		write_reg(CFG_SPARE_IDX, 8'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// one byte, then ticks until the bus waits for the next byte or goes idle
	task automatic put_byte(logic [7:0] b, logic is_last, logic acked, logic offer_busy);
		cmd_t c;
		c = '{cmd_valid: 1'b1, cmd_byte: b, cmd_stop: is_last, sda_in: 1'b1};
		send_tick(c);
		while (ph != PH_IDLE && ph != PH_WAIT) begin
			c.cmd_valid = offer_busy;
			c.cmd_byte = ~b;
			c.cmd_stop = 1'($urandom_range(0, 1));
			c.sda_in = (ph == PH_ACK_HIGH && tcnt == 8'd0) ? !acked :
				1'($urandom_range(0, 1));
			send_tick(c);
		end
	endtask

	task automatic drive_random(int n, int start_pct, int stop_pct, int nack_pct, int noise_pct);
		cmd_t c;
		for (int i = 0; i < n; i++) begin
			c.cmd_byte = 8'($urandom);
			c.cmd_stop = ($urandom_range(0, 99) < stop_pct);
			c.sda_in = 1'($urandom_range(0, 1));
			if (ph == PH_ACK_HIGH && tcnt == 8'd0) c.sda_in = ($urandom_range(0, 99) < nack_pct);
			if (ph == PH_IDLE || ph == PH_WAIT) begin
				c.cmd_valid = ($urandom_range(0, 99) < start_pct);
			end else begin
				c.cmd_valid = ($urandom_range(0, 99) < noise_pct);
			end
			send_tick(c);
		end
	endtask

	task automatic test_reset_timing();
		gaps_on = 1'b0;
		put_byte(8'hA5, 1'b0, 1'b1, 1'b0);
		put_byte(8'h5A, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_directed_cases();
		cmd_t quiet;
		quiet = '{cmd_valid: 1'b0, cmd_byte: 8'h00, cmd_stop: 1'b0, sda_in: 1'b1};
		set_timing(8'd1, 8'd1, 8'd1);
		put_byte(8'hFF, 1'b1, 1'b1, 1'b1);
		// nack mid transaction, the rest is swallowed up to the last byte
		put_byte(8'h00, 1'b0, 1'b0, 1'b0);
		put_byte(8'h3C, 1'b0, 1'b1, 1'b0);
		put_byte(8'hC3, 1'b1, 1'b1, 1'b0);
		put_byte(8'h80, 1'b1, 1'b0, 1'b0);
		put_byte(8'h01, 1'b0, 1'b1, 1'b0);
		repeat (3) send_tick(quiet);
		put_byte(8'hFE, 1'b0, 1'b1, 1'b1);
		put_byte(8'h7F, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_zero_regs();
		set_timing(8'd0, 8'd0, 8'd0);
		put_byte(8'h96, 1'b0, 1'b1, 1'b0);
		put_byte(8'h69, 1'b1, 1'b0, 1'b0);
		gaps_on = 1'b1;
		drive_random(100, 50, 25, 15, 25);
	endtask

	task automatic test_extreme_timing();
		set_timing(8'd1, 8'd1, 8'd64);
		gaps_on = 1'b0;
		put_byte(8'hB4, 1'b1, 1'b1, 1'b0);
		set_timing(8'd1, 8'd16, 8'd1);
		put_byte(8'h4B, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic test_backpressure();
		set_timing(8'd1, 8'd2, 8'd1);
		gaps_on = 1'b0;
		hold_req = 300;
		drive_random(120, 60, 30, 15, 20);
		drain();
		drive_random(60, 60, 30, 15, 20);
	endtask

	task automatic test_random_timing();
		for (int k = 0; k < 5; k++) begin
			set_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
				8'($urandom_range(1, 4)));
			gaps_on = (k % 3 != 0);
			drive_random(100, 50, 25, 15, 25);
		end
	endtask

	initial begin : rx_side
		int wait_cycles;
		res_t want;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = gaps_on ? $urandom_range(0, 9) : 0;
			if (hold_req > 0) begin
				wait_cycles += hold_req;
				hold_req = 0;
			end
			if (wait_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			if (bus_levels_q.size() == 0) begin
				report("result item with nothing expected");
			end else begin
				want = bus_levels_q.pop_front();
				if (res_ch.data.scl_out !== want.scl_out)
					report($sformatf("scl_out got %b want %b", res_ch.data.scl_out, want.scl_out));
				if (res_ch.data.sda_out !== want.sda_out)
					report($sformatf("sda_out got %b want %b", res_ch.data.sda_out, want.sda_out));
				if (res_ch.data.ready_res !== want.ready_res)
					report($sformatf("ready_res got %b want %b", res_ch.data.ready_res,
						want.ready_res));
				if (res_ch.data.byte_done !== want.byte_done)
					report($sformatf("byte_done got %b want %b", res_ch.data.byte_done,
						want.byte_done));
				if (res_ch.data.byte_acked !== want.byte_acked)
					report($sformatf("byte_acked got %b want %b", res_ch.data.byte_acked,
						want.byte_acked));
				if (res_ch.data.trans_done !== want.trans_done)
					report($sformatf("trans_done got %b want %b", res_ch.data.trans_done,
						want.trans_done));
				if (res_ch.data.trans_ok !== want.trans_ok)
					report($sformatf("trans_ok got %b want %b", res_ch.data.trans_ok, want.trans_ok));
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		errors = 0;
		gaps_on = 1'b0;
		hold_req = 0;
		tmg = '{setup_ticks: SETUP_TICKS_RST, high_ticks: HIGH_TICKS_RST,
			hold_ticks: HOLD_TICKS_RST};
		ph = PH_IDLE;
		tcnt = '0;
		sreg = '0;
		bcnt = '0;
		trans_failed = 1'b0;
		stop_after = 1'b0;
		discarding = 1'b0;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= '0;
		cfg_ch.wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_directed_cases();
		test_zero_regs();
		test_extreme_timing();
		test_backpressure();
		test_random_timing();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
